@@ rtl/core/idiv_pkg.sv @@
// Shared constants and types for the shift-subtract integer divider.
package idiv_pkg;

	// Operand width and step counter width
	localparam int DATA_WIDTH = 32;
	localparam int CNT_W      = $clog2(DATA_WIDTH);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DATA_WIDTH - 1);

	// Operation codes on cmd
	localparam logic CMD_UNSIGNED = 1'b0;
	localparam logic CMD_SIGNED   = 1'b1;

	// Control shared by every cell of the row
	typedef struct packed {
		logic load;  // take new operands, clear partial remainder
		logic step;  // perform one shift-subtract iteration
	} cell_ctl_t;

endpackage

@@ rtl/core/idiv_cell.sv @@
// One bit slice of the divider: remainder, dividend/quotient and divisor bits.
module idiv_cell
	import idiv_pkg::*;
(
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  logic      ld_dvd,   // dividend bit on load
	input  logic      ld_dsr,   // divisor bit on load
	input  logic      rem_in,   // shifted-in remainder bit from the lower neighbour
	input  logic      dq_in,    // shifted-in dividend/quotient bit from the lower neighbour
	input  logic      bin,      // borrow from the lower neighbour
	input  logic      sub,      // row-wide decision to keep the difference
	output logic      bout,
	output logic      rem_out,
	output logic      dq_out
);

	logic rem_q;
	logic dq_q;
	logic dsr_q;
	logic diff;

	// Full subtractor on (shifted remainder bit) - (divisor bit) - borrow
	always_comb begin
		diff = rem_in ^ dsr_q ^ bin;
		bout = (~rem_in & (dsr_q | bin)) | (dsr_q & bin & rem_in);
	end

	// Slice state
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rem_q <= 1'b0;
			dq_q  <= ld_dvd;
			dsr_q <= ld_dsr;
		end else if (ctl.step) begin
			rem_q <= sub ? diff : rem_in;
			dq_q  <= dq_in;
		end
	end

	assign rem_out = rem_q;
	assign dq_out  = dq_q;

endmodule

@@ rtl/core/idiv_row.sv @@
// Row of divider bit slices linked by the borrow and shift chains.
module idiv_row
	import idiv_pkg::*;
(
	input  logic                  clk,
	input  cell_ctl_t             ctl,
	input  logic [DATA_WIDTH-1:0] ld_dvd,
	input  logic [DATA_WIDTH-1:0] ld_dsr,
	output logic [DATA_WIDTH-1:0] rem,
	output logic [DATA_WIDTH-1:0] dq
);

	logic [DATA_WIDTH-1:0] borrow;
	logic                  sub;

	// Subtract when the shifted-out remainder bit is set or no final borrow
	assign sub = rem[DATA_WIDTH-1] | ~borrow[DATA_WIDTH-1];

	for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
		logic rem_in;
		logic dq_in;
		logic bin;

		// Slice 0 takes the dividend msb, the new quotient bit and no borrow
		if (i == 0) begin : g_lsb
			assign rem_in = dq[DATA_WIDTH-1];
			assign dq_in  = sub;
			assign bin    = 1'b0;
		end else begin : g_mid
			assign rem_in = rem[i-1];
			assign dq_in  = dq[i-1];
			assign bin    = borrow[i-1];
		end

		idiv_cell u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.ld_dvd  (ld_dvd[i]),
			.ld_dsr  (ld_dsr[i]),
			.rem_in  (rem_in),
			.dq_in   (dq_in),
			.bin     (bin),
			.sub     (sub),
			.bout    (borrow[i]),
			.rem_out (rem[i]),
			.dq_out  (dq[i])
		);
	end

endmodule

@@ rtl/core/int32_divide_signed_unsigned.sv @@
// Top level: signed/unsigned integer divider built on a row of bit slices.
// Each transaction runs 32 shift-subtract steps in the row, then one sign fix-up.
// One transaction at a time: new operands are taken only while idle; the row takes one quotient bit per cycle.
// The result sits in an output register, so the next operands load while it waits.
// Reset (arst_n low, asynchronous) clears the sequencer and out_valid; data is not reset.
module int32_divide_signed_unsigned
	import idiv_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  cmd,
	input  logic [DATA_WIDTH-1:0] dividend,
	input  logic [DATA_WIDTH-1:0] divisor,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [DATA_WIDTH-1:0] quotient,
	output logic [DATA_WIDTH-1:0] remainder,
	output logic                  divide_by_zero
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_FIX  = 3'b100
	} state_t;

	state_t                state_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  neg_q_q;     // quotient needs negating
	logic                  neg_r_q;     // remainder needs negating
	logic                  dz_q;
	logic [DATA_WIDTH-1:0] dvd_q;
	logic [DATA_WIDTH-1:0] quotient_q;
	logic [DATA_WIDTH-1:0] remainder_q;
	logic                  dbz_q;
	logic                  out_valid_q;

	logic                  in_fire;
	logic                  out_fire;
	logic                  fix_fire;
	logic                  dvd_neg;
	logic                  dsr_neg;
	logic [DATA_WIDTH-1:0] mag_dvd;
	logic [DATA_WIDTH-1:0] mag_dsr;
	logic [DATA_WIDTH-1:0] rem;
	logic [DATA_WIDTH-1:0] dq;
	logic [DATA_WIDTH-1:0] q_fix;
	logic [DATA_WIDTH-1:0] r_fix;
	cell_ctl_t             ctl;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid & in_ready;
	assign out_fire = out_valid_q & out_ready;
	assign fix_fire = (state_q == ST_FIX) & (~out_valid_q | out_ready);

	// Operand magnitudes for signed transactions
	always_comb begin
		dvd_neg = (cmd == CMD_SIGNED) & dividend[DATA_WIDTH-1];
		dsr_neg = (cmd == CMD_SIGNED) & divisor[DATA_WIDTH-1];
		mag_dvd = dvd_neg ? (~dividend + DATA_WIDTH'(1)) : dividend;
		mag_dsr = dsr_neg ? (~divisor + DATA_WIDTH'(1)) : divisor;
	end

	assign ctl.load = in_fire;
	assign ctl.step = (state_q == ST_RUN);

	idiv_row u_row (
		.clk    (clk),
		.ctl    (ctl),
		.ld_dvd (mag_dvd),
		.ld_dsr (mag_dsr),
		.rem    (rem),
		.dq     (dq)
	);

	// Sign fix-up and divide-by-zero override
	always_comb begin
		if (dz_q) begin
			q_fix = '0;
			r_fix = dvd_q;
		end else begin
			q_fix = neg_q_q ? (~dq + DATA_WIDTH'(1)) : dq;
			r_fix = neg_r_q ? (~rem + DATA_WIDTH'(1)) : rem;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_RUN;
						cnt_q   <= LAST_STEP;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0) state_q <= ST_FIX;
				end
				ST_FIX: begin
					if (fix_fire) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Per-transaction side information
	always_ff @(posedge clk) begin
		if (in_fire) begin
			neg_q_q <= dvd_neg ^ dsr_neg;
			neg_r_q <= dvd_neg;
			dz_q    <= (divisor == '0);
			dvd_q   <= dividend;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fix_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fix_fire) begin
			quotient_q  <= q_fix;
			remainder_q <= r_fix;
			dbz_q       <= dz_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign quotient       = quotient_q;
	assign remainder      = remainder_q;
	assign divide_by_zero = dbz_q;

endmodule

@@ rtl/core/idiv_checker.sv @@
// Port-level checks for the divider, bound to the top level.
module idiv_checker
	import idiv_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [DATA_WIDTH-1:0] quotient,
	input logic [DATA_WIDTH-1:0] remainder,
	input logic                  divide_by_zero
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(quotient) && $stable(remainder)
			&& $stable(divide_by_zero))
		else $error("result changed while stalled");

	// Only one transaction in flight
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second transaction taken while busy");

	// The row needs its full step count before the next transaction
	a_busy_span: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##33 !in_ready)
		else $error("divider freed too early");

	// Division by zero always reports a zero quotient
	a_dbz_quotient: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_by_zero |-> quotient == '0)
		else $error("non-zero quotient on divide by zero");

endmodule

bind int32_divide_signed_unsigned idiv_checker u_idiv_checker (.*);
